@@ design/rvs_pkg.sv @@
// shared types and constants for the radial vignette scaler
package rvs_pkg;

  localparam int unsigned CfgW       = 13;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CoordW     = 12;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned FactFracW  = 16;
  localparam int unsigned FactW      = FactFracW + 1;
  localparam int unsigned DxW        = CfgW;
  localparam int unsigned DyW        = CoordW;
  localparam int unsigned DxSqW      = 2 * DxW;
  localparam int unsigned DySqW      = 2 * DyW;
  // dx^2 + 4*dy^2 stays below 2^27
  localparam int unsigned SumW       = DxSqW + 1;

  localparam int unsigned MaxDimDflt       = 4096;
  localparam int unsigned DistFracBitsDflt = 8;

  localparam logic [CfgW-1:0] FrameWidthRst  = 13'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pix_t;

endpackage

@@ design/rvs_front.sv @@
// offset from the frame centre, squares and sum of squares, three stages
module rvs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [rvs_pkg::CoordW-1:0]        col_i,
  input  logic [rvs_pkg::CoordW-1:0]        row_i,
  input  rvs_pkg::pix_t                     pix_i,
  input  logic [rvs_pkg::CfgW-1:0]          width_i,
  input  logic [rvs_pkg::CfgW-1:0]          height_i,
  output logic                              valid_o,
  output logic [rvs_pkg::SumW-1:0]          sum_o,
  output rvs_pkg::pix_t                     pix_o
);

  logic [rvs_pkg::DxW-1:0]    col2;
  logic [rvs_pkg::DyW-1:0]    half_h;
  logic [rvs_pkg::DxW-1:0]    dx_d, dx_q;
  logic [rvs_pkg::DyW-1:0]    dy_d, dy_q;
  logic [rvs_pkg::DxSqW-1:0]  dx_sq_q;
  logic [rvs_pkg::DySqW-1:0]  dy_sq_q;
  logic [rvs_pkg::SumW-1:0]   sum_q;
  rvs_pkg::pix_t              pix1_q, pix2_q, pix3_q;
  logic [2:0]                 valid_q;

  always_comb begin
    col2   = {col_i, 1'b0};
    half_h = height_i[rvs_pkg::CfgW-1:1];
    dx_d   = (col2 >= width_i) ? (col2 - width_i) : (width_i - col2);
    dy_d   = (row_i >= half_h) ? (row_i - half_h) : (half_h - row_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      pix1_q  <= pix_i;
      dx_sq_q <= rvs_pkg::DxSqW'(dx_q) * rvs_pkg::DxSqW'(dx_q);
      dy_sq_q <= rvs_pkg::DySqW'(dy_q) * rvs_pkg::DySqW'(dy_q);
      pix2_q  <= pix1_q;
      sum_q   <= rvs_pkg::SumW'(dx_sq_q) + (rvs_pkg::SumW'(dy_sq_q) << 2);
      pix3_q  <= pix2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign sum_o   = sum_q;
  assign pix_o   = pix3_q;

endmodule

@@ design/rvs_sqrt.sv @@
// pipelined integer square root, one root bit per stage
module rvs_sqrt #(
  parameter int unsigned RootW = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*RootW-1:0]   rad_i,
  input  rvs_pkg::pix_t        pix_i,
  output logic                 valid_o,
  output logic [RootW-1:0]     root_o,
  output rvs_pkg::pix_t        pix_o
);

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 2;

  logic [RemW-1:0]   rem_q  [RootW];
  logic [RemW-1:0]   rem_d  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [RootW-1:0]  root_d [RootW];
  logic [RadW-1:0]   rad_q  [RootW];
  logic [RadW-1:0]   rad_d  [RootW];
  rvs_pkg::pix_t     pix_q  [RootW];
  logic [RootW-1:0]  valid_q;

  logic [RemW-1:0]   rem_in, cur, trial;
  logic [RootW-1:0]  root_in;
  logic [RadW-1:0]   rad_in;

  // each stage brings down two radicand bits and decides one root bit
  always_comb begin
    for (int k = 0; k < RootW; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad_i;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      cur   = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
      trial = {root_in, 2'b01};
      if (cur >= trial) begin
        rem_d[k]  = cur - trial;
        root_d[k] = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur;
        root_d[k] = {root_in[RootW-2:0], 1'b0};
      end
      rad_d[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[RootW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RootW; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        if (k == 0) begin
          pix_q[k] <= pix_i;
        end else begin
          pix_q[k] <= pix_q[k-1];
        end
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign pix_o   = pix_q[RootW-1];

endmodule

@@ design/rvs_div.sv @@
// falloff factor: clamp against the radius, then restoring divide by height
module rvs_div #(
  parameter int unsigned DistFracBits = 8,
  parameter int unsigned RootW        = 21
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [RootW-1:0]                 dist_i,
  input  rvs_pkg::pix_t                    pix_i,
  input  logic [rvs_pkg::CfgW-1:0]         height_i,
  output logic                             valid_o,
  output logic [rvs_pkg::FactW-1:0]        factor_o,
  output rvs_pkg::pix_t                    pix_o
);

  localparam int unsigned FullW = rvs_pkg::CfgW + DistFracBits;
  localparam int unsigned CmpW  = (FullW > RootW) ? FullW : RootW;
  localparam int unsigned NumW  = rvs_pkg::CfgW + rvs_pkg::FactFracW;
  localparam int unsigned QW    = rvs_pkg::FactW;
  localparam int unsigned HeadW = NumW - QW;
  localparam int unsigned RemW  = rvs_pkg::CfgW + 1;
  localparam int unsigned NumSh = rvs_pkg::FactFracW - DistFracBits;

  logic [FullW-1:0]  full;
  logic [FullW-1:0]  diff;
  logic              zero_d, zero_pq;
  logic [NumW-1:0]   num_d, num_q;
  rvs_pkg::pix_t     pix_pq;
  logic              valid_pq;

  logic [RemW-1:0]   rem_q  [QW];
  logic [RemW-1:0]   rem_d  [QW];
  logic [QW-1:0]     bits_q [QW];
  logic [QW-1:0]     bits_d [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [QW-1:0]     quo_d  [QW];
  logic              zero_q [QW];
  rvs_pkg::pix_t     pix_q  [QW];
  logic [QW-1:0]     valid_q;

  logic [RemW-1:0]   rem_in, cur, divisor;
  logic [QW-1:0]     bits_in, quo_in;

  always_comb begin
    full   = {height_i, {DistFracBits{1'b0}}};
    zero_d = CmpW'(dist_i) >= CmpW'(full);
    diff   = FullW'(CmpW'(full) - CmpW'(dist_i));
    num_d  = NumW'(diff) << NumSh;
  end

  // the quotient never exceeds 1.0, so the head of the numerator is below height
  always_comb begin
    divisor = {1'b0, height_i};
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_in  = RemW'(num_q[NumW-1 -: HeadW]);
        bits_in = num_q[QW-1:0];
        quo_in  = '0;
      end else begin
        rem_in  = rem_q[k-1];
        bits_in = bits_q[k-1];
        quo_in  = quo_q[k-1];
      end
      cur = {rem_in[RemW-2:0], bits_in[QW-1]};
      if (cur >= divisor) begin
        rem_d[k] = cur - divisor;
        quo_d[k] = {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_d[k] = cur;
        quo_d[k] = {quo_in[QW-2:0], 1'b0};
      end
      bits_d[k] = bits_in << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_pq <= 1'b0;
      valid_q  <= '0;
    end else if (en_i) begin
      valid_pq <= valid_i;
      valid_q  <= {valid_q[QW-2:0], valid_pq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num_d;
      zero_pq <= zero_d;
      pix_pq  <= pix_i;
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= rem_d[k];
        bits_q[k] <= bits_d[k];
        quo_q[k]  <= quo_d[k];
        if (k == 0) begin
          zero_q[k] <= zero_pq;
          pix_q[k]  <= pix_pq;
        end else begin
          zero_q[k] <= zero_q[k-1];
          pix_q[k]  <= pix_q[k-1];
        end
      end
    end
  end

  assign valid_o  = valid_q[QW-1];
  assign factor_o = zero_q[QW-1] ? '0 : quo_q[QW-1];
  assign pix_o    = pix_q[QW-1];

endmodule

@@ design/rvs_scale.sv @@
// channel times factor, truncated, into the output register
module rvs_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rvs_pkg::FactW-1:0]   factor_i,
  input  rvs_pkg::pix_t               pix_i,
  output logic                        valid_o,
  output rvs_pkg::pix_t               pix_o
);

  localparam int unsigned ProdW = rvs_pkg::FactW + rvs_pkg::ChanW;

  logic [ProdW-1:0] prod_b, prod_g, prod_r;
  rvs_pkg::pix_t    pix_d, pix_q;
  logic             valid_q;

  always_comb begin
    prod_b = ProdW'(pix_i.blue)  * ProdW'(factor_i);
    prod_g = ProdW'(pix_i.green) * ProdW'(factor_i);
    prod_r = ProdW'(pix_i.red)   * ProdW'(factor_i);
    pix_d.blue  = prod_b[rvs_pkg::FactFracW +: rvs_pkg::ChanW];
    pix_d.green = prod_g[rvs_pkg::FactFracW +: rvs_pkg::ChanW];
    pix_d.red   = prod_r[rvs_pkg::FactFracW +: rvs_pkg::ChanW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

@@ design/radial_vignette_scaler_unit.sv @@
// radial vignette scaler: config registers and the pixel pipeline
// throughput: one item per cycle while the output is not stalled; the square root
//   resolves one bit per stage and the divider one quotient bit per stage, so every
//   stage takes a new item each cycle
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and loads a 640 x 480 frame
module radial_vignette_scaler_unit #(
  parameter int unsigned MaxDim       = rvs_pkg::MaxDimDflt,
  parameter int unsigned DistFracBits = rvs_pkg::DistFracBitsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rvs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rvs_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rvs_pkg::CoordW-1:0]    pixel_col_i,
  input  logic [rvs_pkg::CoordW-1:0]    pixel_row_i,
  input  logic [rvs_pkg::ChanW-1:0]     in_blue_i,
  input  logic [rvs_pkg::ChanW-1:0]     in_green_i,
  input  logic [rvs_pkg::ChanW-1:0]     in_red_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rvs_pkg::ChanW-1:0]     out_blue_o,
  output logic [rvs_pkg::ChanW-1:0]     out_green_o,
  output logic [rvs_pkg::ChanW-1:0]     out_red_o
);

  localparam int unsigned RadW  = rvs_pkg::SumW + 2 * DistFracBits - 2;
  localparam int unsigned RootW = (RadW + 1) / 2;
  localparam int unsigned RadPW = 2 * RootW;

  logic [rvs_pkg::CfgW-1:0] width_d, width_q;
  logic [rvs_pkg::CfgW-1:0] height_d, height_q;
  logic [rvs_pkg::CfgW-1:0] cfg_clamped;

  logic                        en;
  rvs_pkg::pix_t               pix_in;
  logic                        front_valid;
  logic [rvs_pkg::SumW-1:0]    front_sum;
  rvs_pkg::pix_t               front_pix;
  logic [RadPW-1:0]            rad;
  logic                        sqrt_valid;
  logic [RootW-1:0]            sqrt_root;
  rvs_pkg::pix_t               sqrt_pix;
  logic                        div_valid;
  logic [rvs_pkg::FactW-1:0]   div_factor;
  rvs_pkg::pix_t               div_pix;
  logic                        out_valid;
  rvs_pkg::pix_t               out_pix;

  // dimensions are held already saturated to 1..MaxDim
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = rvs_pkg::CfgW'(1);
    end else if (32'(cfg_data_i) > MaxDim) begin
      cfg_clamped = rvs_pkg::CfgW'(MaxDim);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (rvs_pkg::cfg_reg_e'(cfg_index_i))
        rvs_pkg::CfgFrameWidth:  width_d  = cfg_clamped;
        rvs_pkg::CfgFrameHeight: height_d = cfg_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rvs_pkg::FrameWidthRst;
      height_q <= rvs_pkg::FrameHeightRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // the pipeline advances unless a finished item is held at the output
  assign en         = !out_valid || out_ready_i;
  assign in_ready_o = en;

  assign pix_in.blue  = in_blue_i;
  assign pix_in.green = in_green_i;
  assign pix_in.red   = in_red_i;

  rvs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .col_i    (pixel_col_i),
    .row_i    (pixel_row_i),
    .pix_i    (pix_in),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (front_valid),
    .sum_o    (front_sum),
    .pix_o    (front_pix)
  );

  assign rad = RadPW'(front_sum) << (2 * DistFracBits - 2);

  rvs_sqrt #(
    .RootW (RootW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .rad_i   (rad),
    .pix_i   (front_pix),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root),
    .pix_o   (sqrt_pix)
  );

  rvs_div #(
    .DistFracBits (DistFracBits),
    .RootW        (RootW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sqrt_valid),
    .dist_i   (sqrt_root),
    .pix_i    (sqrt_pix),
    .height_i (height_q),
    .valid_o  (div_valid),
    .factor_o (div_factor),
    .pix_o    (div_pix)
  );

  rvs_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid),
    .factor_i (div_factor),
    .pix_i    (div_pix),
    .valid_o  (out_valid),
    .pix_o    (out_pix)
  );

  assign out_valid_o = out_valid;
  assign out_blue_o  = out_pix.blue;
  assign out_green_o = out_pix.green;
  assign out_red_o   = out_pix.red;

endmodule

@@ dv/radial_vignette_scaler_unit_tb.sv @@
`timescale 1ns / 1ps
// testbench for the radial vignette scaler: random pixel streams checked against a predictor
module radial_vignette_scaler_unit_tb;

  localparam int unsigned DistFrac     = rvs_pkg::DistFracBitsDflt;
  localparam int unsigned MaxDim       = rvs_pkg::MaxDimDflt;
  localparam int unsigned Latency      = 35 + DistFrac;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandPerPhase = 96;
  localparam int unsigned FixedPhases  = 9;
  localparam int unsigned RandPhases   = 3;
  localparam int unsigned ReportMax    = 10;
  localparam logic [rvs_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [rvs_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef enum int unsigned {
    SinkOpen,
    SinkMostly,
    SinkSparse,
    SinkPeriodic
  } sink_mode_e;

  class vignette_tracker;
    logic [rvs_pkg::CfgW-1:0] frame_width;
    logic [rvs_pkg::CfgW-1:0] frame_height;
    rvs_pkg::pix_t            expected_pixels[$];
    int unsigned              failures;

    function new();
      frame_width  = rvs_pkg::FrameWidthRst;
      frame_height = rvs_pkg::FrameHeightRst;
      failures     = 0;
    endfunction

    function void write_reg(logic [rvs_pkg::CfgIdxW-1:0] idx, logic [rvs_pkg::CfgW-1:0] data);
      if (idx == rvs_pkg::CfgFrameWidth) begin
        frame_width = data;
      end else if (idx == rvs_pkg::CfgFrameHeight) begin
        frame_height = data;
      end
    endfunction

    static function bit [63:0] dim_clamp(bit [63:0] v);
      if (v == 0) return 1;
      if (v > MaxDim) return MaxDim;
      return v;
    endfunction

    static function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] b;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v    = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function rvs_pkg::pix_t scaled_pixel(logic [rvs_pkg::CoordW-1:0] col,
                                         logic [rvs_pkg::CoordW-1:0] row,
                                         rvs_pkg::pix_t pin);
      bit [63:0] w, h, c2, r, dx, dy, s, root_dist, full, factor;
      rvs_pkg::pix_t res;
      w  = dim_clamp(frame_width);
      h  = dim_clamp(frame_height);
      c2 = 64'(col) << 1;
      r  = 64'(row);
      dx = (c2 >= w) ? c2 - w : w - c2;
      dy = (r >= h / 2) ? r - h / 2 : h / 2 - r;
      // four times the squared distance, scaled so the root lands in Q.F
      s         = dx * dx + 4 * dy * dy;
      root_dist = root_floor(s << (2 * DistFrac - 2));
      full      = h << DistFrac;
      if (root_dist >= full) begin
        factor = 0;
      end else begin
        factor = ((full - root_dist) << (rvs_pkg::FactFracW - DistFrac)) / h;
      end
      res.blue  = rvs_pkg::ChanW'((64'(pin.blue) * factor) >> rvs_pkg::FactFracW);
      res.green = rvs_pkg::ChanW'((64'(pin.green) * factor) >> rvs_pkg::FactFracW);
      res.red   = rvs_pkg::ChanW'((64'(pin.red) * factor) >> rvs_pkg::FactFracW);
      return res;
    endfunction

    function void note_pixel(logic [rvs_pkg::CoordW-1:0] col, logic [rvs_pkg::CoordW-1:0] row,
                             rvs_pkg::pix_t pin);
      expected_pixels = {expected_pixels, scaled_pixel(col, row, pin)};
    endfunction

    function void check_pixel(rvs_pkg::pix_t got);
      rvs_pkg::pix_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= ReportMax) begin
          $display("unexpected item: b=%0d g=%0d r=%0d", got.blue, got.green, got.red);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red) begin
        failures++;
        if (failures <= ReportMax) begin
          $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                   want.blue, want.green, want.red, got.blue, got.green, got.red);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [rvs_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [rvs_pkg::CfgW-1:0]    cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [rvs_pkg::CoordW-1:0]  pixel_col_i;
  logic [rvs_pkg::CoordW-1:0]  pixel_row_i;
  logic [rvs_pkg::ChanW-1:0]   in_blue_i;
  logic [rvs_pkg::ChanW-1:0]   in_green_i;
  logic [rvs_pkg::ChanW-1:0]   in_red_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [rvs_pkg::ChanW-1:0]   out_blue_o;
  logic [rvs_pkg::ChanW-1:0]   out_green_o;
  logic [rvs_pkg::ChanW-1:0]   out_red_o;

  vignette_tracker tracker;
  bit              hold_req;
  bit              gap_free;
  int unsigned     burst_left;

  logic [rvs_pkg::CfgW-1:0] phase_width  [FixedPhases] = '{
    13'd0, 13'd1, 13'd8191, 13'd4096, 13'd4097, 13'd1, 13'd4095, 13'd7, 13'd640
  };
  logic [rvs_pkg::CfgW-1:0] phase_height [FixedPhases] = '{
    13'd0, 13'd1, 13'd8191, 13'd4096, 13'd1, 13'd4097, 13'd4095, 13'd3, 13'd480
  };

  radial_vignette_scaler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .in_blue_i   (in_blue_i),
    .in_green_i  (in_green_i),
    .in_red_i    (in_red_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_blue_o  (out_blue_o),
    .out_green_o (out_green_o),
    .out_red_o   (out_red_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_pixel(pixel_col_i, pixel_row_i, '{in_blue_i, in_green_i, in_red_i});
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_pixel('{out_blue_o, out_green_o, out_red_o});
      end
    end
  end

  // receiver: stretches of different ready patterns, plus a long hold-off on request
  initial begin
    int unsigned stretch;
    int unsigned hold_left;
    sink_mode_e  mode;
    out_ready_i = 1'b0;
    stretch     = 0;
    hold_left   = 0;
    mode        = SinkOpen;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = sink_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (mode)
          SinkOpen:   out_ready_i <= 1'b1;
          SinkMostly: out_ready_i <= ($urandom_range(0, 3) != 0);
          SinkSparse: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:    out_ready_i <= ((stretch % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic idle_input(int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // offers one item inside the current burst, opening a new burst after a gap when needed
  task automatic offer_pixel(logic [rvs_pkg::CoordW-1:0] col, logic [rvs_pkg::CoordW-1:0] row,
                             logic [rvs_pkg::ChanW-1:0] b, logic [rvs_pkg::ChanW-1:0] g,
                             logic [rvs_pkg::ChanW-1:0] r);
    if (burst_left == 0) begin
      if (!gap_free) idle_input($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    in_blue_i   <= b;
    in_green_i  <= g;
    in_red_i    <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic cfg_write(logic [rvs_pkg::CfgIdxW-1:0] idx, logic [rvs_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_pipeline();
    idle_input(1);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [rvs_pkg::ChanW-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rvs_pkg::ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly inside the frame, some near the centre, some anywhere in the field range
  function automatic logic [rvs_pkg::CoordW-1:0] rand_coord(int unsigned dim);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return rvs_pkg::CoordW'($urandom_range(0, dim - 1));
    if (sel == 7) begin
      return rvs_pkg::CoordW'($urandom_range((dim / 2 >= 3) ? dim / 2 - 3 : 0, dim / 2 + 3));
    end
    return rvs_pkg::CoordW'($urandom_range(0, 4095));
  endfunction

  initial begin
    int unsigned              w_eff;
    int unsigned              h_eff;
    logic [rvs_pkg::CfgW-1:0] w_set;
    logic [rvs_pkg::CfgW-1:0] h_set;
    tracker     = new();
    hold_req    = 1'b0;
    gap_free    = 1'b0;
    burst_left  = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    in_blue_i   = '0;
    in_green_i  = '0;
    in_red_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset frame is 640 x 480, centre at (320, 240), radius 480
    offer_pixel(12'd320, 12'd240, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd320, 12'd240, 8'd0, 8'd0, 8'd0);
    offer_pixel(12'd320, 12'd240, 8'h01, 8'h80, 8'h7f);
    offer_pixel(12'd321, 12'd240, 8'd255, 8'd128, 8'd1);
    offer_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd639, 12'd479, 8'd255, 8'd255, 8'd255);
    // just inside the radius, then exactly on it
    offer_pixel(12'd799, 12'd240, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd800, 12'd240, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd320, 12'd0, 8'd200, 8'd100, 8'd50);
    // outside the frame, on or beyond the radius
    offer_pixel(12'd320, 12'd720, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd0, 12'd4095, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd160, 12'd120, 8'haa, 8'h55, 8'hff);
    offer_pixel(12'd640, 12'd480, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd0, 12'd240, 8'd255, 8'd255, 8'd255);
    offer_pixel(12'd319, 12'd239, 8'd254, 8'd127, 8'd128);

    for (int p = 0; p < FixedPhases + RandPhases; p++) begin
      drain_pipeline();
      if (p < FixedPhases) begin
        w_set = phase_width[p];
        h_set = phase_height[p];
      end else begin
        w_set = ($urandom_range(0, 3) == 0) ? rvs_pkg::CfgW'($urandom)
                                             : rvs_pkg::CfgW'($urandom_range(1, 4096));
        h_set = ($urandom_range(0, 3) == 0) ? rvs_pkg::CfgW'($urandom)
                                             : rvs_pkg::CfgW'($urandom_range(1, 4096));
      end
      cfg_write(rvs_pkg::CfgFrameWidth, w_set);
      cfg_write(rvs_pkg::CfgFrameHeight, h_set);
      if (p == 2) begin
        // writes to unused indexes must leave the frame alone
        cfg_write(CfgSpareA, 13'h1fff);
        cfg_write(CfgSpareB, 13'h0000);
      end
      if (p == 3) begin
        hold_req = 1'b1;
        gap_free = 1'b1;
      end
      w_eff = 32'(tracker.dim_clamp(tracker.frame_width));
      h_eff = 32'(tracker.dim_clamp(tracker.frame_height));
      for (int k = 0; k < RandPerPhase; k++) begin
        if (k == RandPerPhase - 10) gap_free = 1'b0;
        offer_pixel(rand_coord(w_eff), rand_coord(h_eff), rand_chan(), rand_chan(), rand_chan());
      end
    end

    idle_input(1);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rvs_pkg.sv
design/rvs_front.sv
design/rvs_sqrt.sv
design/rvs_div.sv
design/rvs_scale.sv
design/radial_vignette_scaler_unit.sv
dv/radial_vignette_scaler_unit_tb.sv
